/* design/tscap_pkg.sv */
// shared types, codes and constants of the tdma slot/channel allocator
// no dependencies; imported by every design file
package tscap_pkg;

    localparam int MAX_NEIGHBORS_DEF = 32;
    localparam int NUM_SLOTS_DEF     = 7;
    localparam int NUM_CHANNELS_DEF  = 3;

    localparam int COST_CELL  = 10000;
    localparam int COST_SLOT  = 1000;
    localparam int CHAN_BASE  = 12;
    localparam int QDEPTH     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ENTRY_W    = 18;

    localparam logic [1:0] CMD_EPOCH  = 2'd0;
    localparam logic [1:0] CMD_BEACON = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;
    localparam logic [1:0] CMD_SCHED  = 2'd3;

    localparam logic [1:0] ACT_IDLE = 2'd0;
    localparam logic [1:0] ACT_TX   = 2'd1;
    localparam logic [1:0] ACT_RX   = 2'd2;

    localparam logic [0:0] KIND_BEACON = 1'b0;
    localparam logic [0:0] KIND_SLOT   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RX    = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        beacon_payload;
        logic signed [7:0]  beacon_rssi;
        logic [15:0]        random_value;
    } in_item_t;

    typedef struct packed {
        logic [0:0] result_kind;
        logic [9:0] own_beacon;
        logic [2:0] slot_index;
        logic [1:0] slot_action;
        logic [3:0] radio_channel;
        logic [4:0] target_id;
        logic [0:0] last;
    } out_item_t;

    // entry layout: rssi 17:10, channel 9:8, slot 7:5, id 4:0
    typedef struct packed {
        logic [1:0]         op;
        logic [ENTRY_W-1:0] entry;
        logic [15:0]        rnd;
    } work_t;

    typedef struct packed {
        logic [4:0]        own_id;
        logic signed [7:0] rssi_threshold;
        logic [2:0]        max_rx;
    } cfg_t;

endpackage

/* design/tscap_front.sv */
// front end: accepts items, drops malformed beacons, queues work for the back end
// depends on tscap_pkg
module tscap_front
    import tscap_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     q_valid,
    output work_t    q_item,
    input  logic     q_pop
);

    localparam int PW = $clog2(QDEPTH);

    work_t             fifo_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       cnt_reg;
    logic              drop;
    logic              push;
    work_t             item;

    always_comb
    begin
        item.op    = in_data.command;
        item.entry = {in_data.beacon_rssi, in_data.beacon_payload[9:0]};
        item.rnd   = in_data.random_value;
        drop = (in_data.command == CMD_BEACON) &&
               (({1'b0, in_data.beacon_payload[7:5]} >= 4'(NUM_SLOTS)) ||
                ({1'b0, in_data.beacon_payload[9:8]} >= 3'(NUM_CHANNELS)));
    end

    assign in_ready = (cnt_reg < (PW+1)'(QDEPTH));
    assign push     = in_valid && in_ready && !drop;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* design/tscap_back.sv */
// back end: neighbor store, cost grid, tie-break remainder, schedule passes, output register
// depends on tscap_pkg
module tscap_back
    import tscap_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  work_t     q_item,
    output logic      q_pop,
    input  cfg_t      cfg,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW     = $clog2(MAX_NEIGHBORS + 1);
    localparam int NCELL  = NUM_SLOTS * NUM_CHANNELS;
    localparam int TW     = $clog2(NCELL + 1);
    localparam int COST_MAX = MAX_NEIGHBORS * (COST_CELL + COST_SLOT);
    localparam int COSTW  = $clog2(COST_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PSCAN, ST_PMIN, ST_PMOD, ST_PSEL, ST_POUT, ST_SSCAN, ST_SOUT
    } state_t;

    state_t                  state_reg;
    logic [ENTRY_W-1:0]      mem [MAX_NEIGHBORS];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_vld_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           scan_addr_reg;
    logic [2:0]              my_slot_reg;
    logic [1:0]              my_chan_reg;
    logic [15:0]             rnd_reg;
    logic [COSTW-1:0]        cost_reg [NUM_SLOTS][NUM_CHANNELS];
    logic [COSTW-1:0]        best_reg;
    logic [TW-1:0]           ties_reg;
    logic [TW-1:0]           rem_reg;
    logic [TW-1:0]           k_reg;
    logic [3:0]              bit_reg;
    logic [2:0]              cell_s_reg;
    logic [1:0]              cell_c_reg;
    logic [1:0]              act_reg [NUM_SLOTS];
    logic [3:0]              chn_reg [NUM_SLOTS];
    logic [4:0]              tgt_reg [NUM_SLOTS];
    logic                    first_reg;
    logic                    have_next_reg;
    logic signed [7:0]       level_reg;
    logic signed [7:0]       next_reg;
    logic [2:0]              assigned_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic                    scanning;
    logic                    issuing;
    logic                    pass_done;
    logic                    out_free;
    logic                    emit;
    logic                    mem_we;
    logic [2:0]              d_slot;
    logic [1:0]              d_chan;
    logic [4:0]              d_id;
    logic signed [7:0]       d_rssi;
    logic                    above_thr;
    logic [COSTW-1:0]        cur_cost;
    logic                    cell_last;
    logic [TW:0]             mod_tmp;

    assign scanning  = (state_reg == ST_PSCAN) || (state_reg == ST_SSCAN);
    assign issuing   = scanning && (scan_addr_reg < count_reg);
    assign pass_done = scanning && (scan_addr_reg == count_reg) && !rd_vld_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = ((state_reg == ST_POUT) || (state_reg == ST_SOUT)) && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.op == CMD_BEACON) &&
                       (count_reg < CW'(MAX_NEIGHBORS));

    assign d_id   = rd_data_reg[4:0];
    assign d_slot = rd_data_reg[7:5];
    assign d_chan = rd_data_reg[9:8];
    assign d_rssi = rd_data_reg[17:10];
    assign above_thr = (d_rssi > cfg.rssi_threshold);

    assign cur_cost  = cost_reg[cell_s_reg][cell_c_reg];
    assign cell_last = (cell_s_reg == 3'(NUM_SLOTS - 1)) &&
                       (cell_c_reg == 2'(NUM_CHANNELS - 1));
    assign mod_tmp   = {rem_reg, rnd_reg[bit_reg]};

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // neighbor store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= q_item.entry;
        end
        rd_data_reg <= mem[scan_addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            my_slot_reg   <= '0;
            my_chan_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issuing;
            if (issuing)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        rnd_reg       <= q_item.rnd;
                        scan_addr_reg <= '0;
                        unique case (q_item.op)
                            CMD_EPOCH:
                            begin
                                count_reg <= '0;
                            end
                            CMD_BEACON:
                            begin
                                if (mem_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_PICK:
                            begin
                                for (int s = 0; s < NUM_SLOTS; s++)
                                begin
                                    for (int c = 0; c < NUM_CHANNELS; c++)
                                    begin
                                        cost_reg[s][c] <= '0;
                                    end
                                end
                                state_reg <= ST_PSCAN;
                            end
                            CMD_SCHED:
                            begin
                                for (int s = 0; s < NUM_SLOTS; s++)
                                begin
                                    if (3'(s) == my_slot_reg)
                                    begin
                                        act_reg[s] <= ACT_TX;
                                        chn_reg[s] <= {2'b00, my_chan_reg} + 4'(CHAN_BASE);
                                    end
                                    else
                                    begin
                                        act_reg[s] <= ACT_IDLE;
                                        chn_reg[s] <= '0;
                                    end
                                    tgt_reg[s] <= '0;
                                end
                                first_reg     <= 1'b1;
                                have_next_reg <= 1'b0;
                                assigned_reg  <= '0;
                                state_reg     <= ST_SSCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // accumulate cell costs, one neighbor per cycle
                ST_PSCAN:
                begin
                    if (rd_vld_reg)
                    begin
                        for (int s = 0; s < NUM_SLOTS; s++)
                        begin
                            for (int c = 0; c < NUM_CHANNELS; c++)
                            begin
                                if (3'(s) == d_slot)
                                begin
                                    if (2'(c) == d_chan)
                                    begin
                                        cost_reg[s][c] <= cost_reg[s][c] + COSTW'(COST_CELL) +
                                            (above_thr ? COSTW'(COST_SLOT) : '0);
                                    end
                                    else if (above_thr)
                                    begin
                                        cost_reg[s][c] <= cost_reg[s][c] + COSTW'(COST_SLOT);
                                    end
                                end
                            end
                        end
                    end
                    if (pass_done)
                    begin
                        cell_s_reg <= '0;
                        cell_c_reg <= '0;
                        state_reg  <= ST_PMIN;
                    end
                end

                // running minimum and tie count over cells
                ST_PMIN:
                begin
                    if ((cell_s_reg == '0 && cell_c_reg == '0) || (cur_cost < best_reg))
                    begin
                        best_reg <= cur_cost;
                        ties_reg <= TW'(1);
                    end
                    else if (cur_cost == best_reg)
                    begin
                        ties_reg <= ties_reg + 1'b1;
                    end
                    if (cell_last)
                    begin
                        cell_s_reg <= '0;
                        cell_c_reg <= '0;
                        rem_reg    <= '0;
                        bit_reg    <= 4'd15;
                        state_reg  <= ST_PMOD;
                    end
                    else if (cell_c_reg == 2'(NUM_CHANNELS - 1))
                    begin
                        cell_c_reg <= '0;
                        cell_s_reg <= cell_s_reg + 1'b1;
                    end
                    else
                    begin
                        cell_c_reg <= cell_c_reg + 1'b1;
                    end
                end

                // random value mod tie count, one bit per cycle
                ST_PMOD:
                begin
                    if (mod_tmp >= {1'b0, ties_reg})
                    begin
                        rem_reg <= TW'(mod_tmp - {1'b0, ties_reg});
                    end
                    else
                    begin
                        rem_reg <= TW'(mod_tmp);
                    end
                    if (bit_reg == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_PSEL;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end

                ST_PSEL:
                begin
                    if (cur_cost == best_reg)
                    begin
                        if (k_reg == rem_reg)
                        begin
                            my_slot_reg <= cell_s_reg;
                            my_chan_reg <= cell_c_reg;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                    if (cell_last)
                    begin
                        state_reg <= ST_POUT;
                    end
                    else if (cell_c_reg == 2'(NUM_CHANNELS - 1))
                    begin
                        cell_c_reg <= '0;
                        cell_s_reg <= cell_s_reg + 1'b1;
                    end
                    else
                    begin
                        cell_c_reg <= cell_c_reg + 1'b1;
                    end
                end

                ST_POUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg.result_kind   <= KIND_BEACON;
                        out_data_reg.own_beacon    <= {my_chan_reg, my_slot_reg, cfg.own_id};
                        out_data_reg.slot_index    <= '0;
                        out_data_reg.slot_action   <= ACT_IDLE;
                        out_data_reg.radio_channel <= '0;
                        out_data_reg.target_id     <= '0;
                        out_data_reg.last          <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                end

                // one pass per rssi level, strongest first, arrival order within a level
                ST_SSCAN:
                begin
                    if (rd_vld_reg)
                    begin
                        if (first_reg || (d_rssi < level_reg))
                        begin
                            if (!have_next_reg || (d_rssi > next_reg))
                            begin
                                next_reg      <= d_rssi;
                                have_next_reg <= 1'b1;
                            end
                        end
                        if (!first_reg && (d_rssi == level_reg) &&
                            (assigned_reg < cfg.max_rx))
                        begin
                            for (int s = 0; s < NUM_SLOTS; s++)
                            begin
                                if ((3'(s) == d_slot) && (act_reg[s] == ACT_IDLE))
                                begin
                                    act_reg[s]   <= ACT_RX;
                                    chn_reg[s]   <= {2'b00, d_chan} + 4'(CHAN_BASE);
                                    tgt_reg[s]   <= d_id;
                                    assigned_reg <= assigned_reg + 1'b1;
                                end
                            end
                        end
                    end
                    if (pass_done)
                    begin
                        if (!have_next_reg || (assigned_reg >= cfg.max_rx))
                        begin
                            cell_s_reg <= '0;
                            state_reg  <= ST_SOUT;
                        end
                        else
                        begin
                            level_reg     <= next_reg;
                            have_next_reg <= 1'b0;
                            first_reg     <= 1'b0;
                            scan_addr_reg <= '0;
                        end
                    end
                end

                ST_SOUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg.result_kind   <= KIND_SLOT;
                        out_data_reg.own_beacon    <= '0;
                        out_data_reg.slot_index    <= cell_s_reg;
                        out_data_reg.slot_action   <= act_reg[cell_s_reg];
                        out_data_reg.radio_channel <= chn_reg[cell_s_reg];
                        out_data_reg.target_id     <= tgt_reg[cell_s_reg];
                        out_data_reg.last          <= (cell_s_reg == 3'(NUM_SLOTS - 1));
                        if (cell_s_reg == 3'(NUM_SLOTS - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cell_s_reg <= cell_s_reg + 1'b1;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/tdma_slot_channel_allocator_top.sv */
// epoch and beacon items are handled in the back end idle state; malformed beacons are
//   dropped in the front end; a pick scans the neighbor store, walks the cells for the
//   minimum and tie count, forms the remainder one bit a cycle, walks the cells again to
//   select, then emits its result; a schedule scans the store once to find the strongest
//   level and once per rssi level walked, then emits one slot entry at a time
// one item is worked at a time; a 2-entry queue lets the input side run ahead
// reset: async active low; store empty, own slot/channel 0, registers at defaults
module tdma_slot_channel_allocator_top
    import tscap_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    cfg_t  cfg_reg;
    // queue between front and back
    logic  q_valid;
    logic  q_pop;
    work_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id         <= '0;
            cfg_reg.rssi_threshold <= -8'sd85;
            cfg_reg.max_rx         <= 3'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_ID:    cfg_reg.own_id         <= cfg_wdata[4:0];
                REG_THRESHOLD: cfg_reg.rssi_threshold <= cfg_wdata;
                REG_MAX_RX:    cfg_reg.max_rx         <= cfg_wdata[2:0];
                default:       cfg_reg                <= cfg_reg;   // unused index
            endcase
        end
    end

    // front: accept, drop malformed beacons, queue
    tscap_front #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: store, pick and schedule engines, output register
    tscap_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .NUM_SLOTS     (NUM_SLOTS),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // a pick result is always the only one of its item
    a_pick_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_BEACON |-> out_data.last)
        else $error("pick result without last");

    // active slot entries carry an offset channel, idle ones none
    a_slot_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_SLOT && out_data.slot_action != ACT_IDLE
        |-> out_data.radio_channel >= 4'(CHAN_BASE))
        else $error("active slot with bad channel");

    // back end only pops a queued item
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* tb/sv/tdma_slot_channel_allocator_top_test.sv */
// self-checking testbench of tdma_slot_channel_allocator_top: a scoreboard class predicts
// picks and schedules from every accepted item; depends on tscap_pkg and the top level
module tdma_slot_channel_allocator_top_test;
    import tscap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB_MAX = MAX_NEIGHBORS_DEF;
    localparam int SLOTS  = NUM_SLOTS_DEF;
    localparam int CHANS  = NUM_CHANNELS_DEF;

    // one stored neighbor as the predictor keeps it
    typedef struct {
        logic [4:0]        id;
        logic [2:0]        slot;
        logic [1:0]        chan;
        logic signed [7:0] rssi;
    } neighbor_t;

    class alloc_scoreboard;
        out_item_t         pending_q[$];
        neighbor_t         heard[NB_MAX];
        int                heard_n;
        logic [2:0]        cur_slot;
        logic [1:0]        cur_chan;
        logic [4:0]        own_id;
        logic signed [7:0] threshold;
        logic [2:0]        max_rx;
        int                errors;
        int                results;
        int                picks;
        int                scheds;
        int                dropped;

        function new();
            heard_n   = 0;
            cur_slot  = '0;
            cur_chan  = '0;
            own_id    = '0;
            threshold = -8'sd85;
            max_rx    = 3'd5;
            errors    = 0;
            results   = 0;
            picks     = 0;
            scheds    = 0;
            dropped   = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_OWN_ID) own_id = val[4:0];
            else if (idx == REG_THRESHOLD) threshold = $signed(val);
            else if (idx == REG_MAX_RX) max_rx = val[2:0];
        endfunction

        // cost grid, cheapest cell, tie pick by remainder
        function void predict_pick(logic [15:0] rnd);
            int        cost[SLOTS][CHANS];
            int        best;
            int        ties;
            int        sel;
            int        k;
            out_item_t o;
            foreach (cost[s, c]) cost[s][c] = 0;
            for (int i = 0; i < heard_n; i++)
            begin
                cost[heard[i].slot][heard[i].chan] += COST_CELL;
                if (heard[i].rssi > threshold)
                    for (int c = 0; c < CHANS; c++) cost[heard[i].slot][c] += COST_SLOT;
            end
            best = cost[0][0];
            ties = 0;
            foreach (cost[s, c]) if (cost[s][c] < best) best = cost[s][c];
            foreach (cost[s, c]) if (cost[s][c] == best) ties++;
            sel = int'(rnd) % ties;
            k = 0;
            for (int s = 0; s < SLOTS; s++)
                for (int c = 0; c < CHANS; c++)
                    if (cost[s][c] == best)
                    begin
                        if (k == sel)
                        begin
                            cur_slot = 3'(s);
                            cur_chan = 2'(c);
                        end
                        k++;
                    end
            o = '0;
            o.result_kind = KIND_BEACON;
            o.own_beacon  = {cur_chan, cur_slot, own_id};
            o.last        = 1'b1;
            pending_q.insert(pending_q.size(), o);
            picks++;
        endfunction

        // own tx slot, then strongest neighbors claim their rx slots
        function void predict_schedule();
            logic [1:0] act[SLOTS];
            logic [3:0] chn[SLOTS];
            logic [4:0] tgt[SLOTS];
            int         order[$];
            int         j;
            int         assigned;
            out_item_t  o;
            for (int i = 0; i < SLOTS; i++)
            begin
                act[i] = ACT_IDLE;
                chn[i] = '0;
                tgt[i] = '0;
            end
            act[cur_slot] = ACT_TX;
            chn[cur_slot] = 4'(cur_chan + CHAN_BASE);
            // stable descending sort on rssi
            for (int i = 0; i < heard_n; i++)
            begin
                j = 0;
                while (j < order.size() && heard[order[j]].rssi >= heard[i].rssi) j++;
                order.insert(j, i);
            end
            assigned = 0;
            foreach (order[i])
            begin
                if (assigned >= max_rx) break;
                if (heard[order[i]].slot != cur_slot && act[heard[order[i]].slot] == ACT_IDLE)
                begin
                    act[heard[order[i]].slot] = ACT_RX;
                    chn[heard[order[i]].slot] = 4'(heard[order[i]].chan + CHAN_BASE);
                    tgt[heard[order[i]].slot] = heard[order[i]].id;
                    assigned++;
                end
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                o = '0;
                o.result_kind   = KIND_SLOT;
                o.slot_index    = 3'(i);
                o.slot_action   = act[i];
                o.radio_channel = chn[i];
                o.target_id     = tgt[i];
                o.last          = (i == SLOTS - 1);
                pending_q.insert(pending_q.size(), o);
            end
            scheds++;
        endfunction

        function void note_item(in_item_t it);
            logic [2:0] s;
            logic [1:0] c;
            s = it.beacon_payload[7:5];
            c = it.beacon_payload[9:8];
            case (it.command)
                CMD_EPOCH: heard_n = 0;
                CMD_BEACON:
                begin
                    if (s >= SLOTS || c >= CHANS || heard_n >= NB_MAX) dropped++;
                    else
                    begin
                        heard[heard_n] = '{it.beacon_payload[4:0], s, c, it.beacon_rssi};
                        heard_n++;
                    end
                end
                CMD_PICK: predict_pick(it.random_value);
                default: predict_schedule();
            endcase
        endfunction

        task check_result(out_item_t got);
            out_item_t w;
            results++;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            w = pending_q.pop_front();
            if (got.result_kind !== w.result_kind)
                report($sformatf("result_kind %h, want %h", got.result_kind, w.result_kind));
            if (got.own_beacon !== w.own_beacon)
                report($sformatf("own_beacon %h, want %h", got.own_beacon, w.own_beacon));
            if (got.slot_index !== w.slot_index)
                report($sformatf("slot_index %h, want %h", got.slot_index, w.slot_index));
            if (got.slot_action !== w.slot_action)
                report($sformatf("slot_action %h, want %h", got.slot_action, w.slot_action));
            if (got.radio_channel !== w.radio_channel)
                report($sformatf("radio_channel %h, want %h", got.radio_channel,
                                 w.radio_channel));
            if (got.target_id !== w.target_id)
                report($sformatf("target_id %h, want %h", got.target_id, w.target_id));
            if (got.last !== w.last)
                report($sformatf("last %h, want %h", got.last, w.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    alloc_scoreboard sb;
    int  send_idle_pct;   // chance in a hundred that the sender idles a cycle
    int  recv_stall_pct;  // chance in a hundred that the receiver stalls a cycle
    bit  hold_request;    // asks the receiver for one long hold-off
    int  items_sent;

    tdma_slot_channel_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard limit, far above the slowest legal run
    initial
    begin
        #40ms;
        $display("tdma_slot_channel_allocator_top: mismatch");
        $finish;
    end

    // receiver: checks each accepted item, stalls at random, one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(out_data);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 4000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // offer one item, hold it until accepted; called right after a rising edge
    task send_item(logic [1:0] cmd, logic [15:0] pay, logic signed [7:0] rssi,
                   logic [15:0] rnd);
        in_item_t it;
        it = '{cmd, pay, rssi, rnd};
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // drop valid and wait until every expected result is back
    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    // block is idle only after the longest silent item has worked out too
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task write_config(logic [4:0] id, logic signed [7:0] thr, logic [2:0] mrx);
        wait_drained();
        repeat (1500) @(posedge clk);
        write_reg(REG_OWN_ID, {3'b000, id});
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MAX_RX, {5'b00000, mrx});
    endtask

    // rssi values bunched around the threshold so ties and edges show up
    function logic signed [7:0] pick_rssi();
        logic signed [7:0] r;
        case ($urandom_range(0, 9))
            0: r = -8'sd128;
            1: r = 8'sd127;
            2: r = sb.threshold;
            3: r = sb.threshold + 8'sd1;
            4: r = -8'sd60;
            default: r = 8'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    // well-formed beacon with random upper bits, or now and then a fully random one that may be out of range
    task send_beacon();
        logic [15:0] pay;
        pay = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) != 0)
        begin
            pay[7:5] = 3'($urandom_range(0, SLOTS - 1));
            pay[9:8] = 2'($urandom_range(0, CHANS - 1));
        end
        send_item(CMD_BEACON, pay, pick_rssi(), 16'($urandom_range(0, 65535)));
    endtask

    // one round: usually clear, hear beacons, then one to three picks, schedules or beacons
    task run_round();
        int nb;
        int ops;
        if ($urandom_range(0, 5) != 0)
            send_item(CMD_EPOCH, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
        // now and then overfill the store
        nb = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 9);
        repeat (nb) send_beacon();
        ops = $urandom_range(1, 3);
        repeat (ops)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: send_item(CMD_PICK, 16'($urandom_range(0, 65535)),
                                   8'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 65535)));
                3, 4: send_item(CMD_SCHED, 16'($urandom_range(0, 65535)),
                                8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)));
                default: send_beacon();
            endcase
        end
    endtask

    initial
    begin : stimulus
        int phase_goal;
        sb = new();
        items_sent     = 0;
        hold_request   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults after reset, empty-store pick and schedule
        send_item(CMD_PICK, 16'h0000, 8'sd0, 16'hFFFF);
        send_item(CMD_SCHED, 16'hFFFF, -8'sd1, 16'h0000);
        send_item(CMD_EPOCH, 16'hFFFF, -8'sd1, 16'hFFFF);
        // dropped beacons: slot out of range, channel out of range, both
        send_item(CMD_BEACON, 16'h00E0, 8'sd127, 16'h0000);
        send_item(CMD_BEACON, 16'h0300, 8'sd127, 16'h0000);
        send_item(CMD_BEACON, 16'hFFFF, -8'sd1, 16'hFFFF);
        // extremes of id, slot, channel, rssi; upper payload bits set
        send_item(CMD_BEACON, 16'hFEDF, 8'sd127, 16'hFFFF);
        send_item(CMD_BEACON, 16'h0000, -8'sd128, 16'h0000);
        // rssi exactly at and just above the threshold, equal rssi order
        send_item(CMD_BEACON, 16'h0145, -8'sd85, 16'h1234);
        send_item(CMD_BEACON, 16'h0066, -8'sd84, 16'h0000);
        send_item(CMD_BEACON, 16'h0087, -8'sd84, 16'h0000);
        send_item(CMD_BEACON, 16'h00C8, 8'sd127, 16'h0000);
        send_item(CMD_PICK, 16'h0000, 8'sd0, 16'h0000);
        send_item(CMD_PICK, 16'hFFFF, 8'sd0, 16'hFFFF);
        send_item(CMD_SCHED, 16'h0000, 8'sd0, 16'h0000);
        send_item(CMD_EPOCH, 16'h0000, 8'sd0, 16'h0000);
        send_item(CMD_SCHED, 16'h0000, 8'sd0, 16'h0000);

        // random phases over settings and idling patterns
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_config(5'd31, -8'sd128, 3'd7);
                1: write_config(5'd0, 8'sd127, 3'd0);
                2: write_config(5'd21, -8'sd85, 3'd5);
                3: write_config(5'd10, -8'sd60, 3'd3);
                default: write_config(5'd17, -8'sd90, 3'd1);
            endcase
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 22; recv_stall_pct = 22; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            phase_goal = items_sent + 80;
            if (p == 4) hold_request = 1'b1;  // receiver holds off while items pile up
            while (items_sent < phase_goal)
            begin
                run_round();
                if (p == 0 && items_sent >= phase_goal - 40 && items_sent < phase_goal - 30)
                    wait_drained();  // sender pauses until all results are in
            end
        end

        wait_drained();
        repeat (2000) @(posedge clk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never came", sb.pending_q.size()));
        $display("covered %0d items: %0d picks, %0d schedules, %0d dropped beacons, %0d results",
                 items_sent, sb.picks, sb.scheds, sb.dropped, sb.results);
        if (sb.errors == 0)
            $display("tdma_slot_channel_allocator_top: match");
        else
            $display("tdma_slot_channel_allocator_top: mismatch");
        $finish;
    end
endmodule
